### rtl/pbf_pkg.sv
// ----------------------------------------------------------------------------
// pbf_pkg
// types, command codes and register indexes of the packed bit field table
// ----------------------------------------------------------------------------
package pbf_pkg;

    localparam int STORE_BYTES    = 4096;
    localparam int MAX_ENTRY_BITS = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_FP_BITS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRIES      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUCKET_COUNT = 2'd2;

    localparam logic [1:0] CMD_RD_ENTRY = 2'd0;
    localparam logic [1:0] CMD_WR_ENTRY = 2'd1;
    localparam logic [1:0] CMD_RD_BYTE  = 2'd2;
    localparam logic [1:0] CMD_WR_BYTE  = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] bucket_index;
        logic [5:0]  entry_index;
        logic [31:0] entry_value;
        logic [11:0] byte_address;
        logic [7:0]  byte_value;
    } t_pbf_in;

    typedef struct packed {
        logic [31:0] read_value;
        logic        error;
    } t_pbf_out;

endpackage

### rtl/pbf_ram.sv
// ----------------------------------------------------------------------------
// pbf_ram
// single port synchronous ram, registered read (not updated during a write)
// ----------------------------------------------------------------------------
module pbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                        i_wdata,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/packed_bit_field_table.sv
// ----------------------------------------------------------------------------
// packed_bit_field_table
// table of fixed-width entries packed msb first into a byte-wide memory
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store to zero, one byte per cycle
// with busy high; configuration writes are taken during the sweep. A command
// is taken when start is high and busy is low, and its single result shows
// on o_result with o_strobe high for one cycle; it cannot be held off.
// A raw byte write answers in the next cycle without raising busy, a raw
// byte read through S_RAW with busy high. An entry command walks the byte
// memory port one byte per cycle over the n bytes (1 to 5) the entry covers,
// a read through S_POS, S_LOC, S_RD and S_MOD, a write also through S_WR.
// A rejected entry command answers from S_LOC with the error bit set.
// ----------------------------------------------------------------------------
module packed_bit_field_table #(
    parameter int STORE_BYTES = pbf_pkg::STORE_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pbf_pkg::t_pbf_in                  i_cmd,
    output logic                              o_strobe,
    output pbf_pkg::t_pbf_out                 o_result,
    input  logic                              i_cfg_we,
    input  logic [pbf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pbf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import pbf_pkg::*;

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(STORE_BYTES - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_POS   = 3'd2;
    localparam logic [2:0] S_LOC   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_MOD   = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;
    localparam logic [2:0] S_RAW   = 3'd7;

    // control
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [2:0]    r_cnt, n_cnt;
    logic          r_pend, n_pend;
    logic          r_strobe, n_strobe;
    logic [5:0]    r_fp_bits;
    logic [6:0]    r_entries;
    logic [12:0]   r_bucket_count;

    // payload
    logic [1:0]   r_cmd, n_cmd;
    logic [31:0]  r_value, n_value;
    logic         r_bad, n_bad;
    logic [18:0]  r_index, n_index;
    logic [24:0]  r_pos, n_pos;
    logic [21:0]  r_first, n_first;
    logic [2:0]   r_nbytes, n_nbytes;
    logic [5:0]   r_shift, n_shift;
    logic [39:0]  r_win, n_win;
    t_pbf_out     r_result, n_result;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    // datapath
    logic [31:0] raw_ext;
    logic        raw_oob;
    logic [31:0] ent_addr;
    logic [25:0] end_bit;
    logic [22:0] last_byte;
    logic [2:0]  loc_nbytes;
    logic        loc_oob;
    logic [39:0] fmask;
    logic [31:0] rd_value;
    logic [39:0] new_win;
    logic [2:0]  wr_sel;
    logic [7:0]  wr_byte;

    pbf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    assign raw_ext    = 32'(i_cmd.byte_address);
    assign raw_oob    = (raw_ext >= 32'(STORE_BYTES));
    assign ent_addr   = 32'(r_first) + 32'(r_cnt);
    assign end_bit    = 26'(r_pos) + 26'(r_fp_bits) - 26'd1;
    assign last_byte  = end_bit[25:3];
    assign loc_nbytes = 3'(last_byte - {1'b0, r_pos[24:3]} + 23'd1);
    assign loc_oob    = (32'(last_byte) >= 32'(STORE_BYTES));
    assign fmask      = (40'd1 << r_fp_bits) - 40'd1;
    assign rd_value   = 32'((r_win >> r_shift) & fmask);
    assign new_win    = (r_win & ~(fmask << r_shift)) | ((40'(r_value) & fmask) << r_shift);
    assign wr_sel     = r_nbytes - 3'd1 - r_cnt;
    assign wr_byte    = 8'(r_win >> {wr_sel, 3'b000});

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_cnt     = r_cnt;
        n_pend    = r_pend;
        n_strobe  = 1'b0;
        n_cmd     = r_cmd;
        n_value   = r_value;
        n_bad     = r_bad;
        n_index   = r_index;
        n_pos     = r_pos;
        n_first   = r_first;
        n_nbytes  = r_nbytes;
        n_shift   = r_shift;
        n_win     = r_win;
        n_result  = r_result;
        mem_we    = 1'b0;
        mem_addr  = ent_addr[AW-1:0];
        mem_wdata = wr_byte;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = 8'd0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                mem_addr = raw_ext[AW-1:0];
                if (start) begin
                    n_cmd   = i_cmd.cmd;
                    n_value = i_cmd.entry_value;
                    n_index = 19'(r_entries * i_cmd.bucket_index)
                            + 19'(i_cmd.entry_index);
                    n_bad   = (r_fp_bits == 6'd0)
                            || (32'(r_fp_bits) > 32'(MAX_ENTRY_BITS))
                            || ({1'b0, i_cmd.bucket_index} >= r_bucket_count)
                            || ({1'b0, i_cmd.entry_index} >= r_entries);
                    if (i_cmd.cmd == CMD_RD_ENTRY || i_cmd.cmd == CMD_WR_ENTRY) begin
                        n_state = S_POS;
                    end else if (raw_oob) begin
                        n_strobe            = 1'b1;
                        n_result.read_value = 32'd0;
                        n_result.error      = 1'b1;
                    end else if (i_cmd.cmd == CMD_RD_BYTE) begin
                        n_state = S_RAW;
                    end else begin
                        mem_we              = 1'b1;
                        mem_wdata           = i_cmd.byte_value;
                        n_strobe            = 1'b1;
                        n_result.read_value = 32'd0;
                        n_result.error      = 1'b0;
                    end
                end
            end
            S_POS: begin
                n_pos   = 25'(r_fp_bits * r_index);
                n_state = S_LOC;
            end
            S_LOC: begin
                n_first  = r_pos[24:3];
                n_nbytes = loc_nbytes;
                n_shift  = 6'({loc_nbytes, 3'b000}) - 6'(r_pos[2:0]) - r_fp_bits;
                n_win    = 40'd0;
                n_cnt    = 3'd0;
                n_pend   = 1'b0;
                if (r_bad || loc_oob) begin
                    n_strobe            = 1'b1;
                    n_result.read_value = 32'd0;
                    n_result.error      = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_pend) begin
                    n_win = {r_win[31:0], mem_rdata};
                end
                if (r_cnt != r_nbytes) begin
                    n_cnt  = r_cnt + 3'd1;
                    n_pend = 1'b1;
                end else begin
                    n_cnt   = 3'd0;
                    n_pend  = 1'b0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (r_cmd == CMD_RD_ENTRY) begin
                    n_strobe            = 1'b1;
                    n_result.read_value = rd_value;
                    n_result.error      = 1'b0;
                    n_state             = S_IDLE;
                end else begin
                    n_win   = new_win;
                    n_cnt   = 3'd0;
                    n_state = S_WR;
                end
            end
            S_WR: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + 3'd1;
                if (r_cnt == r_nbytes - 3'd1) begin
                    n_strobe            = 1'b1;
                    n_result.read_value = 32'd0;
                    n_result.error      = 1'b0;
                    n_state             = S_IDLE;
                end
            end
            S_RAW: begin
                n_strobe            = 1'b1;
                n_result.read_value = 32'(mem_rdata);
                n_result.error      = 1'b0;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_cnt          <= '0;
            r_pend         <= 1'b0;
            r_strobe       <= 1'b0;
            r_fp_bits      <= 6'd8;
            r_entries      <= 7'd4;
            r_bucket_count <= 13'd1024;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cnt    <= n_cnt;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FP_BITS:      r_fp_bits      <= i_cfg_data[5:0];
                    CFG_ENTRIES:      r_entries      <= i_cfg_data[6:0];
                    CFG_BUCKET_COUNT: r_bucket_count <= i_cfg_data[12:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_value  <= n_value;
        r_bad    <= n_bad;
        r_index  <= n_index;
        r_pos    <= n_pos;
        r_first  <= n_first;
        r_nbytes <= n_nbytes;
        r_shift  <= n_shift;
        r_win    <= n_win;
        r_result <= n_result;
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.error |-> o_result.read_value == 32'd0)
        else $error("rejected transaction returned nonzero data");

    a_raw_wr_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd.cmd == CMD_WR_BYTE |=> o_strobe && !busy)
        else $error("raw byte write did not answer in the next cycle");

    a_entry_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd.cmd == CMD_RD_ENTRY || i_cmd.cmd == CMD_WR_ENTRY)
        |=> busy && !o_strobe)
        else $error("entry transaction did not hold busy");

    a_no_strobe_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_strobe && !n_strobe)
        else $error("result raised during store clear");

endmodule

### verif/tb_packed_bit_field_table.sv
// ----------------------------------------------------------------------------
// tb_packed_bit_field_table
// self-checking testbench for the packed bit field table
// ----------------------------------------------------------------------------
// Commands go in through the start/busy handshake. Every accepted transaction
// is run through a table model kept here (byte image plus layout registers),
// and its answer is queued. Each strobed result is compared field by field
// with the oldest queued answer. A directed part covers reset contents, field
// extremes, five-byte straddles, wide write values and rejected commands; a
// random part then runs phases over several layouts, including the extremes,
// mostly with in-range indices packed close together so that writes and reads
// overlap, and some fully random noise. The layout is only changed while the
// block is idle.
// ----------------------------------------------------------------------------
module tb_packed_bit_field_table;
    timeunit 1ns;
    timeprecision 1ps;

    import pbf_pkg::*;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    t_pbf_in                i_cmd       = '0;
    logic                   o_strobe;
    t_pbf_out               o_result;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    logic [7:0]  byte_mem [STORE_BYTES];
    logic [5:0]  cfg_fp;
    logic [6:0]  cfg_epb;
    logic [12:0] cfg_bc;

    t_pbf_out    answers_due [$];
    t_pbf_out    answer;
    int          mismatch_count = 0;
    bit          gaps_on = 1'b1;

    packed_bit_field_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_pbf_out table_access(t_pbf_in c);
        t_pbf_out        res;
        longint unsigned row, pos, last, first;
        int unsigned     nbytes, shift;
        logic [63:0]     window, mask;
        res = '0;
        if (c.cmd == CMD_RD_ENTRY || c.cmd == CMD_WR_ENTRY) begin
            if (cfg_fp == 0 || cfg_fp > MAX_ENTRY_BITS ||
                c.bucket_index >= cfg_bc || c.entry_index >= cfg_epb) begin
                res.error = 1'b1;
            end else begin
                row  = 64'(cfg_epb);
                row  = row * c.bucket_index + c.entry_index;
                pos  = row * cfg_fp;
                last = (pos + cfg_fp - 1) >> 3;
                if (last >= STORE_BYTES) begin
                    res.error = 1'b1;
                end else begin
                    first  = pos >> 3;
                    nbytes = 32'(last - first + 1);
                    shift  = 32'(nbytes * 8 - (pos % 8) - cfg_fp);
                    window = '0;
                    for (int i = 0; i < nbytes; i++) begin
                        window = (window << 8) | 64'(byte_mem[first + i]);
                    end
                    mask = (64'd1 << cfg_fp) - 64'd1;
                    if (c.cmd == CMD_RD_ENTRY) begin
                        res.read_value = 32'((window >> shift) & mask);
                    end else begin
                        window = (window & ~(mask << shift)) |
                                 ((64'(c.entry_value) & mask) << shift);
                        for (int i = 0; i < nbytes; i++) begin
                            byte_mem[first + i] = 8'(window >> (8 * (nbytes - 1 - i)));
                        end
                    end
                end
            end
        end else if (c.byte_address >= STORE_BYTES) begin
            res.error = 1'b1;
        end else if (c.cmd == CMD_RD_BYTE) begin
            res.read_value = {24'd0, byte_mem[c.byte_address]};
        end else begin
            byte_mem[c.byte_address] = c.byte_value;
        end
        return res;
    endfunction

    function automatic t_pbf_in noise_command();
        t_pbf_in c;
        c.cmd          = 2'($urandom);
        c.bucket_index = 12'($urandom);
        c.entry_index  = 6'($urandom);
        c.entry_value  = $urandom;
        c.byte_address = 12'($urandom);
        c.byte_value   = 8'($urandom);
        return c;
    endfunction

    function automatic t_pbf_in make_command(logic [1:0] op, int bucket, int entry,
                                             logic [31:0] value, int addr,
                                             logic [7:0] bval);
        t_pbf_in c;
        c.cmd          = op;
        c.bucket_index = 12'(bucket);
        c.entry_index  = 6'(entry);
        c.entry_value  = value;
        c.byte_address = 12'(addr);
        c.byte_value   = bval;
        return c;
    endfunction

    // mostly in-range indices clustered near the start of the store, otherwise noise
    function automatic t_pbf_in draw_command();
        t_pbf_in c;
        int      rows, lim, hot;
        c = noise_command();
        if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 1) == 0) begin
                c.byte_address = 12'($urandom_range(0, 31));
            end
            if (cfg_fp != 0 && cfg_fp <= MAX_ENTRY_BITS && cfg_epb != 0 && cfg_bc != 0) begin
                rows = (STORE_BYTES * 8) / (cfg_fp * cfg_epb);
                lim  = (rows < cfg_bc) ? rows : cfg_bc;
                lim  = (lim < 4096) ? lim : 4096;
                if (lim > 0) begin
                    hot = (lim < 6) ? lim : 6;
                    c.bucket_index = 12'(($urandom_range(0, 3) != 0) ?
                                         $urandom_range(0, hot - 1) :
                                         $urandom_range(0, lim - 1));
                    c.entry_index  = 6'($urandom_range(0, ((cfg_epb < 64) ? cfg_epb : 64) - 1));
                end
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < 50) begin
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (answers_due.size() == 0) begin
                report_mismatch("transaction with nothing pending", o_result.read_value, '0);
            end else begin
                answer = answers_due.pop_front();
                if (o_result.read_value !== answer.read_value) begin
                    report_mismatch("read_value", o_result.read_value, answer.read_value);
                end
                if (o_result.error !== answer.error) begin
                    report_mismatch("error", 32'(o_result.error), 32'(answer.error));
                end
            end
        end
    end

    task automatic issue_command(t_pbf_in c);
        t_pbf_out due;
        i_cmd <= c;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        due = table_access(c);
        answers_due = {answers_due, due};
    endtask

    task automatic idle_gap();
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            i_cmd <= noise_command();
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (answers_due.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic set_layout(int fp, int epb, int bc);
        logic [CFG_DATA_W-1:0] data [3];
        logic [CFG_INDEX_W-1:0] index [3];
        data[0] = CFG_DATA_W'(fp);  index[0] = CFG_FP_BITS;
        data[1] = CFG_DATA_W'(epb); index[1] = CFG_ENTRIES;
        data[2] = CFG_DATA_W'(bc);  index[2] = CFG_BUCKET_COUNT;
        wait_idle();
        for (int i = 0; i < 3; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= index[i];
            i_cfg_data  <= data[i];
            @(posedge i_clk);
            case (index[i])
                CFG_FP_BITS: cfg_fp  = data[i][5:0];
                CFG_ENTRIES: cfg_epb = data[i][6:0];
                default:     cfg_bc  = data[i][12:0];
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_contents();
        issue_command(make_command(CMD_RD_ENTRY, 0, 0, '0, 0, '0));
        issue_command(make_command(CMD_RD_ENTRY, 1023, 3, '0, 0, '0));
        issue_command(make_command(CMD_RD_ENTRY, 1024, 0, '0, 0, '0));
        issue_command(make_command(CMD_RD_ENTRY, 0, 4, '0, 0, '0));
        issue_command(make_command(CMD_RD_BYTE, 0, 0, '0, 4095, '0));
    endtask

    task automatic test_entry_extremes();
        set_layout(32, 64, 4096);
        issue_command(make_command(CMD_WR_ENTRY, 15, 63, 32'hFFFF_FFFF, 0, '0));
        issue_command(make_command(CMD_RD_ENTRY, 15, 63, '0, 0, '0));
        issue_command(make_command(CMD_RD_BYTE, 0, 0, '0, 4095, '0));
        issue_command(make_command(CMD_WR_ENTRY, 16, 0, 32'h1234_5678, 0, '0));
        issue_command(make_command(CMD_RD_ENTRY, 4095, 63, '0, 0, '0));
    endtask

    task automatic test_five_byte_straddle();
        set_layout(31, 2, 4096);
        issue_command(make_command(CMD_WR_ENTRY, 0, 1, 32'h5555_5555, 0, '0));
        issue_command(make_command(CMD_RD_ENTRY, 0, 1, '0, 0, '0));
        issue_command(make_command(CMD_RD_ENTRY, 0, 0, '0, 0, '0));
        issue_command(make_command(CMD_RD_BYTE, 0, 0, '0, 3, '0));
    endtask

    task automatic test_wide_value_and_raw();
        set_layout(5, 64, 4095);
        issue_command(make_command(CMD_WR_ENTRY, 0, 1, 32'hFFFF_FFFF, 0, '0));
        issue_command(make_command(CMD_RD_ENTRY, 0, 0, '0, 0, '0));
        issue_command(make_command(CMD_RD_ENTRY, 0, 2, '0, 0, '0));
        issue_command(make_command(CMD_WR_BYTE, 0, 0, '0, 0, 8'hA5));
        issue_command(make_command(CMD_RD_ENTRY, 0, 0, '0, 0, '0));
        issue_command(make_command(CMD_RD_ENTRY, 0, 1, '0, 0, '0));
    endtask

    task automatic test_rejected_layouts();
        set_layout(0, 4, 16);
        issue_command(make_command(CMD_RD_ENTRY, 0, 0, '0, 0, '0));
        issue_command(make_command(CMD_WR_BYTE, 0, 0, '0, 7, 8'h3C));
        set_layout(33, 4, 16);
        issue_command(make_command(CMD_WR_ENTRY, 0, 0, 32'hFFFF_FFFF, 0, '0));
        set_layout(8, 0, 16);
        issue_command(make_command(CMD_RD_ENTRY, 0, 0, '0, 0, '0));
        set_layout(8, 4, 0);
        issue_command(make_command(CMD_WR_ENTRY, 0, 0, 32'h0000_00FF, 0, '0));
        issue_command(make_command(CMD_RD_BYTE, 0, 0, '0, 7, '0));
    endtask

    task automatic run_phase(int fp, int epb, int bc, int count, bit gaps);
        set_layout(fp, epb, bc);
        gaps_on = gaps;
        for (int n = 0; n < count; n++) begin
            issue_command(draw_command());
            idle_gap();
        end
    endtask

    task automatic test_random_layouts();
        int fp, epb, bc;
        run_phase(8, 4, 1024, 60, 1'b1);
        run_phase(32, 127, 8191, 50, 1'b1);
        run_phase(1, 1, 1, 40, 1'b1);
        run_phase(13, 7, 300, 50, 1'b0);
        for (int p = 0; p < 5; p++) begin
            fp  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
            epb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
            bc  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) :
                                                 $urandom_range(1, 4096);
            run_phase(fp, epb, bc, 50, 1'($urandom_range(0, 1)));
        end
        run_phase(31, 3, 50, 50, 1'b0);
        run_phase(3, 64, 4095, 50, 1'b0);
    endtask

    initial begin
        for (int i = 0; i < STORE_BYTES; i++) begin
            byte_mem[i] = '0;
        end
        cfg_fp  = 6'd8;
        cfg_epb = 7'd4;
        cfg_bc  = 13'd1024;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_entry_extremes();
        test_five_byte_straddle();
        test_wide_value_and_raw();
        test_rejected_layouts();
        test_random_layouts();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && answers_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/pbf_pkg.sv
rtl/pbf_ram.sv
rtl/packed_bit_field_table.sv
verif/tb_packed_bit_field_table.sv
